// ===== rtl/core/bpc_pkg.sv =====
// Package for the barometric pressure compensation block.
// Holds shared constants, types and helper functions; no dependencies.
package bpc_pkg;

   localparam int OVERSAMPLING = 3;
   localparam int OSS          = OVERSAMPLING & 3;

   localparam int DIV_STEPS = 32;
   localparam int SIDE_W    = 64;
   localparam int ADDR_W    = 5;

   localparam logic [31:0] B7_SCALE   = 32'(50000 >> OSS);
   localparam logic [31:0] K_4000     = 32'd4000;
   localparam logic [31:0] K_3038     = 32'd3038;
   localparam logic [31:0] K_M7357    = 32'hFFFF_E343;
   localparam logic [31:0] K_3791     = 32'd3791;
   localparam logic [31:0] K_32768    = 32'd32768;
   localparam logic [31:0] K_SIGN     = 32'h8000_0000;
   localparam logic [31:0] P_MAX      = 32'd262143;
   localparam logic [31:0] T_MIN      = 32'hFFFF_8000;
   localparam logic [31:0] T_MAX      = 32'd32767;

   localparam logic [2:0] REG_AC1   = 3'd0;
   localparam logic [2:0] REG_AC2   = 3'd1;
   localparam logic [2:0] REG_AC3   = 3'd2;
   localparam logic [2:0] REG_AC4   = 3'd3;
   localparam logic [2:0] REG_AC5   = 3'd4;
   localparam logic [2:0] REG_AC6   = 3'd5;
   localparam logic [2:0] REG_B1_B2 = 3'd6;
   localparam logic [2:0] REG_MC_MD = 3'd7;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
   } coef_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       num;
      logic [31:0]       den;
      logic [SIDE_W-1:0] side;
   } div_req_type;

   typedef struct packed {
      logic              valid;
      logic [31:0]       quo;
      logic [SIDE_W-1:0] side;
   } div_rsp_type;

   // Sideband carried through the temperature divider.
   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        err;
   } side1_type;

   // Sideband carried through the pressure divider.
   typedef struct packed {
      logic [15:0] temp;
      logic        halved;
      logic        err;
   } side2_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input int n);
      return 32'($signed(v) >>> n);
   endfunction

endpackage

// ===== rtl/core/bpc_req_if.sv =====
// Input channel carrying one raw temperature and pressure pair.
// Uses no package.
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [18:0] raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// ===== rtl/core/bpc_rsp_if.sv =====
// Result channel carrying compensated pressure and temperature.
// Uses no package.
interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [17:0] pressure_pa;
   logic [15:0] temperature_tenths;
   logic        divide_error;

   modport source (output valid, output pressure_pa, output temperature_tenths,
                   output divide_error, input ready);
   modport sink   (input valid, input pressure_pa, input temperature_tenths,
                   input divide_error, output ready);
endinterface

// ===== rtl/core/barometric_pressure_compensation.sv =====
// Barometric pressure compensation: one raw temperature and pressure pair enters per cycle
// when not stalled and leaves as pressure in pascals and temperature in tenths of a degree.
// The path holds two 32-stage dividers, one for the temperature term and one for pressure,
// plus thirteen arithmetic stages and the output register. A stall at the result side holds
// the whole pipeline; nothing is dropped. Coefficients are read live, so write them only while
// no transfer is in flight. A zero divisor gives divide_error with both results zero.
module barometric_pressure_compensation (
   input  logic                       clock,
   input  logic                       reset,
   bpc_req_if.sink                    req_ch,
   bpc_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   bpc_pkg::coef_type coef;
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic        adv;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   assign ac1 = bpc_pkg::sx16(coef.ac1);
   assign ac2 = bpc_pkg::sx16(coef.ac2);
   assign ac3 = bpc_pkg::sx16(coef.ac3);
   assign ac4 = {16'b0, coef.ac4};
   assign ac5 = {16'b0, coef.ac5};
   assign ac6 = {16'b0, coef.ac6};
   assign b1  = bpc_pkg::sx16(coef.b1_b2[31:16]);
   assign b2  = bpc_pkg::sx16(coef.b1_b2[15:0]);
   assign mc  = bpc_pkg::sx16(coef.mc_md[31:16]);
   assign md  = bpc_pkg::sx16(coef.mc_md[15:0]);

   // The whole pipeline moves together unless a finished result is waiting.
   logic rsp_vld_ff;
   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Valid bits of the arithmetic stages.
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic s8_v_ff, s9_v_ff, s10_v_ff, s11_v_ff, s12_v_ff, s13_v_ff;

   bpc_pkg::div_rsp_type d1_rsp, d2_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0; s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0; s6_v_ff <= 1'b0; s7_v_ff <= 1'b0; s8_v_ff <= 1'b0;
         s9_v_ff <= 1'b0; s10_v_ff <= 1'b0; s11_v_ff <= 1'b0; s12_v_ff <= 1'b0;
         s13_v_ff <= 1'b0; rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_ch.valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= d1_rsp.valid;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= s7_v_ff;
         s9_v_ff  <= s8_v_ff;
         s10_v_ff <= s9_v_ff;
         s11_v_ff <= d2_rsp.valid;
         s12_v_ff <= s11_v_ff;
         s13_v_ff <= s12_v_ff;
         rsp_vld_ff <= s13_v_ff;
      end
   end

   // Stages 1 to 4: input capture, x1 and the temperature divider operands.
   logic [15:0] s1_ut_ff;
   logic [18:0] s1_up_ff, s2_up_ff, s3_up_ff;
   logic [31:0] s2_d_ff, s3_x1_ff;
   logic [31:0] s2_d_in, s3_prod, s3_x1_in;
   logic [31:0] s4_num_ff, s4_den_ff;
   logic [31:0] den1, num1, s4_num_in, s4_den_in;
   bpc_pkg::side1_type s4_side_ff, s4_side_in;

   assign s2_d_in  = {16'b0, s1_ut_ff} - ac6;
   assign s3_prod  = s2_d_ff * ac5;
   assign s3_x1_in = bpc_pkg::asr(s3_prod, 15);
   assign den1     = s3_x1_ff + md;
   assign num1     = {mc[20:0], 11'b0};
   assign s4_num_in = num1[31] ? (32'd0 - num1) : num1;
   assign s4_den_in = den1[31] ? (32'd0 - den1) : den1;

   always_comb begin
      s4_side_in.x1  = s3_x1_ff;
      s4_side_in.up  = s3_up_ff;
      s4_side_in.neg = num1[31] ^ den1[31];
      s4_side_in.err = den1 == 32'd0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ut_ff   <= req_ch.raw_temperature;
         s1_up_ff   <= req_ch.raw_pressure;
         s2_d_ff    <= s2_d_in;
         s2_up_ff   <= s1_up_ff;
         s3_x1_ff   <= s3_x1_in;
         s3_up_ff   <= s2_up_ff;
         s4_num_ff  <= s4_num_in;
         s4_den_ff  <= s4_den_in;
         s4_side_ff <= s4_side_in;
      end
   end

   bpc_pkg::div_req_type d1_req;
   assign d1_req.valid = s4_v_ff;
   assign d1_req.num   = s4_num_ff;
   assign d1_req.den   = s4_den_ff;
   assign d1_req.side  = bpc_pkg::SIDE_W'(s4_side_ff);

   bpc_div u_div_temp (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .req   (d1_req),
      .rsp   (d1_rsp)
   );

   // Stages 5 to 10: b5, temperature, b3, b4 and b7.
   bpc_pkg::side1_type d1_side;
   logic [31:0] x2_t, s5_b5_in, s5_b5_ff;
   logic [18:0] s5_up_ff, s6_up_ff, s7_up_ff, s8_up_ff, s9_up_ff;
   logic        s5_err_ff, s6_err_ff, s7_err_ff, s8_err_ff, s9_err_ff, s10_err_ff;
   logic [31:0] s6_b6_ff, s6_b6_in, t_full;
   logic [15:0] t_sat, s6_t_ff, s7_t_ff, s8_t_ff, s9_t_ff, s10_t_ff;

   assign d1_side  = bpc_pkg::side1_type'(d1_rsp.side[$bits(bpc_pkg::side1_type)-1:0]);
   assign x2_t     = d1_side.neg ? (32'd0 - d1_rsp.quo) : d1_rsp.quo;
   assign s5_b5_in = d1_side.x1 + x2_t;
   assign s6_b6_in = s5_b5_ff - bpc_pkg::K_4000;
   assign t_full   = bpc_pkg::asr(s5_b5_ff + 32'd8, 4);

   always_comb begin
      if (t_full[31]) begin
         t_sat = (t_full < bpc_pkg::T_MIN) ? 16'h8000 : t_full[15:0];
      end else begin
         t_sat = (t_full > bpc_pkg::T_MAX) ? 16'h7FFF : t_full[15:0];
      end
   end

   logic [31:0] s7_sq_ff, s7_m2_ff, s7_m3_ff, sq_prod, m2_in, m3_in;
   logic [31:0] s8_x1_ff, s8_x2_ff, s8_xa_ff, s8_xb_ff, p_b2, p_b1;
   logic [31:0] s9_b3_ff, s9_x3_ff, b3_sum, b3_in, x3_in;
   logic [31:0] s10_b4_ff, s10_b7_ff, b4_prod, b4_in, b7_in;

   assign sq_prod = s6_b6_ff * s6_b6_ff;
   assign m2_in   = ac2 * s6_b6_ff;
   assign m3_in   = ac3 * s6_b6_ff;
   assign p_b2    = b2 * s7_sq_ff;
   assign p_b1    = b1 * s7_sq_ff;
   assign b3_sum  = 32'({ac1[29:0], 2'b0} + s8_x1_ff + s8_x2_ff) << bpc_pkg::OSS;
   assign b3_in   = bpc_pkg::asr(b3_sum + 32'd2, 2);
   assign x3_in   = bpc_pkg::asr(s8_xa_ff + s8_xb_ff + 32'd2, 2);
   assign b4_prod = ac4 * (s9_x3_ff + bpc_pkg::K_32768);
   assign b4_in   = b4_prod >> 15;
   assign b7_in   = ({13'b0, s9_up_ff} - s9_b3_ff) * bpc_pkg::B7_SCALE;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_b5_ff   <= s5_b5_in;
         s5_up_ff   <= d1_side.up;
         s5_err_ff  <= d1_side.err;
         s6_b6_ff   <= s6_b6_in;
         s6_t_ff    <= t_sat;
         s6_up_ff   <= s5_up_ff;
         s6_err_ff  <= s5_err_ff;
         s7_sq_ff   <= bpc_pkg::asr(sq_prod, 12);
         s7_m2_ff   <= m2_in;
         s7_m3_ff   <= m3_in;
         s7_t_ff    <= s6_t_ff;
         s7_up_ff   <= s6_up_ff;
         s7_err_ff  <= s6_err_ff;
         s8_x1_ff   <= bpc_pkg::asr(p_b2, 11);
         s8_x2_ff   <= bpc_pkg::asr(s7_m2_ff, 11);
         s8_xa_ff   <= bpc_pkg::asr(s7_m3_ff, 13);
         s8_xb_ff   <= bpc_pkg::asr(p_b1, 16);
         s8_t_ff    <= s7_t_ff;
         s8_up_ff   <= s7_up_ff;
         s8_err_ff  <= s7_err_ff;
         s9_b3_ff   <= b3_in;
         s9_x3_ff   <= x3_in;
         s9_t_ff    <= s8_t_ff;
         s9_up_ff   <= s8_up_ff;
         s9_err_ff  <= s8_err_ff;
         s10_b4_ff  <= b4_in;
         s10_b7_ff  <= b7_in;
         s10_t_ff   <= s9_t_ff;
         s10_err_ff <= s9_err_ff || (b4_in == 32'd0);
      end
   end

   // When b7 has its top bit set, divide b7 itself and double the quotient afterward.
   bpc_pkg::div_req_type d2_req;
   bpc_pkg::side2_type   d2_side_in, d2_side;

   always_comb begin
      d2_side_in.temp   = s10_t_ff;
      d2_side_in.halved = s10_b7_ff[31];
      d2_side_in.err    = s10_err_ff;
   end

   assign d2_req.valid = s10_v_ff;
   assign d2_req.num   = s10_b7_ff[31] ? s10_b7_ff : {s10_b7_ff[30:0], 1'b0};
   assign d2_req.den   = s10_b4_ff;
   assign d2_req.side  = bpc_pkg::SIDE_W'(d2_side_in);

   bpc_div u_div_press (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .req   (d2_req),
      .rsp   (d2_rsp)
   );

   // Stages 11 to 13 and the output register: pressure correction and saturation.
   assign d2_side = bpc_pkg::side2_type'(d2_rsp.side[$bits(bpc_pkg::side2_type)-1:0]);

   logic [31:0] s11_p_ff, s12_p_ff, s13_p_ff, p_in, pp;
   logic [31:0] s12_x1_ff, s12_x2_ff, s13_x1_ff, s13_x2_ff, x1_scaled;
   logic [15:0] s11_t_ff, s12_t_ff, s13_t_ff;
   logic        s11_err_ff, s12_err_ff, s13_err_ff;
   logic [31:0] pr, corr;
   logic [17:0] p_sat;

   assign p_in      = d2_side.halved ? {d2_rsp.quo[30:0], 1'b0} : d2_rsp.quo;
   assign pp        = bpc_pkg::asr(s11_p_ff, 8);
   assign x1_scaled = s12_x1_ff * bpc_pkg::K_3038;
   assign corr      = bpc_pkg::asr(s13_x1_ff + s13_x2_ff + bpc_pkg::K_3791, 4);
   assign pr        = s13_p_ff + corr;

   always_comb begin
      if (pr[31]) begin
         p_sat = '0;
      end else if (pr > bpc_pkg::P_MAX) begin
         p_sat = bpc_pkg::P_MAX[17:0];
      end else begin
         p_sat = pr[17:0];
      end
   end

   logic [17:0] rsp_p_ff;
   logic [15:0] rsp_t_ff;
   logic        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_p_ff   <= p_in;
         s11_t_ff   <= d2_side.temp;
         s11_err_ff <= d2_side.err;
         s12_x1_ff  <= pp * pp;
         s12_x2_ff  <= bpc_pkg::K_M7357 * s11_p_ff;
         s12_p_ff   <= s11_p_ff;
         s12_t_ff   <= s11_t_ff;
         s12_err_ff <= s11_err_ff;
         s13_x1_ff  <= bpc_pkg::asr(x1_scaled, 16);
         s13_x2_ff  <= bpc_pkg::asr(s12_x2_ff, 16);
         s13_p_ff   <= s12_p_ff;
         s13_t_ff   <= s12_t_ff;
         s13_err_ff <= s12_err_ff;
         rsp_p_ff   <= s13_err_ff ? '0 : p_sat;
         rsp_t_ff   <= s13_err_ff ? '0 : s13_t_ff;
         rsp_err_ff <= s13_err_ff;
      end
   end

   assign rsp_ch.valid              = rsp_vld_ff;
   assign rsp_ch.pressure_pa        = rsp_p_ff;
   assign rsp_ch.temperature_tenths = rsp_t_ff;
   assign rsp_ch.divide_error       = rsp_err_ff;
endmodule

// ===== rtl/core/bpc_csr.sv =====
// Calibration coefficient registers behind an APB-style port.
// Depends on bpc_pkg for the coefficient type and register codes.
module bpc_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output bpc_pkg::coef_type         coef
);
   bpc_pkg::coef_type coef_ff;
   bpc_pkg::coef_type coef_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (idx)
            bpc_pkg::REG_AC1:   coef_in.ac1   = csr_pwdata[15:0];
            bpc_pkg::REG_AC2:   coef_in.ac2   = csr_pwdata[15:0];
            bpc_pkg::REG_AC3:   coef_in.ac3   = csr_pwdata[15:0];
            bpc_pkg::REG_AC4:   coef_in.ac4   = csr_pwdata[15:0];
            bpc_pkg::REG_AC5:   coef_in.ac5   = csr_pwdata[15:0];
            bpc_pkg::REG_AC6:   coef_in.ac6   = csr_pwdata[15:0];
            bpc_pkg::REG_B1_B2: coef_in.b1_b2 = csr_pwdata;
            bpc_pkg::REG_MC_MD: coef_in.mc_md = csr_pwdata;
            default:            coef_in       = coef_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bpc_pkg::REG_AC1:   csr_prdata = {16'b0, coef_ff.ac1};
         bpc_pkg::REG_AC2:   csr_prdata = {16'b0, coef_ff.ac2};
         bpc_pkg::REG_AC3:   csr_prdata = {16'b0, coef_ff.ac3};
         bpc_pkg::REG_AC4:   csr_prdata = {16'b0, coef_ff.ac4};
         bpc_pkg::REG_AC5:   csr_prdata = {16'b0, coef_ff.ac5};
         bpc_pkg::REG_AC6:   csr_prdata = {16'b0, coef_ff.ac6};
         bpc_pkg::REG_B1_B2: csr_prdata = coef_ff.b1_b2;
         bpc_pkg::REG_MC_MD: csr_prdata = coef_ff.mc_md;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.ac1   <= 16'd408;
         coef_ff.ac2   <= 16'hFFB8;
         coef_ff.ac3   <= 16'hC7D1;
         coef_ff.ac4   <= 16'd32741;
         coef_ff.ac5   <= 16'd32757;
         coef_ff.ac6   <= 16'd23153;
         coef_ff.b1_b2 <= 32'd405667844;
         coef_ff.mc_md <= 32'd3724086068;
      end else begin
         coef_ff <= coef_in;
      end
   end
endmodule

// ===== rtl/core/bpc_div.sv =====
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the request and response types.
module bpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  bpc_pkg::div_req_type req,
   output bpc_pkg::div_rsp_type rsp
);
   localparam int N = bpc_pkg::DIV_STEPS;

   logic [31:0]               rem_ff  [0:N-1];
   logic [31:0]               nq_ff   [0:N-1];
   logic [31:0]               den_ff  [0:N-1];
   logic [bpc_pkg::SIDE_W-1:0] side_ff [0:N-1];
   logic                      vld_ff  [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [31:0]               rem_prev;
      logic [31:0]               nq_prev;
      logic [31:0]               den_prev;
      logic [bpc_pkg::SIDE_W-1:0] side_prev;
      logic                      vld_prev;
      logic [32:0]               trial;
      logic [32:0]               diff;
      logic                      ge;
      logic [31:0]               rem_in;
      logic [31:0]               nq_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign nq_prev   = req.num;
         assign den_prev  = req.den;
         assign side_prev = req.side;
         assign vld_prev  = req.valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign nq_prev   = nq_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // The quotient bits shift into the low end as the dividend leaves the top.
      assign trial  = {rem_prev, nq_prev[31]};
      assign diff   = trial - {1'b0, den_prev};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? diff[31:0] : trial[31:0];
      assign nq_in  = {nq_prev[30:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign rsp.valid = vld_ff[N-1];
   assign rsp.quo   = nq_ff[N-1];
   assign rsp.side  = side_ff[N-1];
endmodule

// ===== rtl/core/bpc_checker.sv =====
// Port-level checks for the barometric pressure compensation block.
// Bound to the top level; uses no package.
module bpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [17:0] rsp_pressure_pa,
   input logic [15:0] rsp_temperature_tenths,
   input logic        rsp_divide_error
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_pressure_pa == 18'd0 &&
                                        rsp_temperature_tenths == 16'd0)
      else $error("divide error with nonzero results");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure_pa) &&
                                  $stable(rsp_temperature_tenths))
      else $error("stalled result changed");
endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_ch.ready),
   .rsp_valid              (rsp_ch.valid),
   .rsp_ready              (rsp_ch.ready),
   .rsp_pressure_pa        (rsp_ch.pressure_pa),
   .rsp_temperature_tenths (rsp_ch.temperature_tenths),
   .rsp_divide_error       (rsp_ch.divide_error)
);

// ===== dv/barometric_pressure_compensation_tb.sv =====
// Self-checking testbench for the barometric pressure compensation block.
// Depends on bpc_pkg, bpc_req_if, bpc_rsp_if and the top module; predicts every result from
// its own coefficient copy and compares each result transfer against the oldest prediction.
module barometric_pressure_compensation_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [18:0] raw_pressure;
   } sample_type;

   typedef struct packed {
      logic [17:0] pressure_pa;
      logic [15:0] temperature_tenths;
      logic        divide_error;
   } reading_type;

   logic clock;
   logic reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [bpc_pkg::ADDR_W-1:0] csr_paddr;
   logic [31:0]                csr_pwdata;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();

   barometric_pressure_compensation dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Coefficient copy used for prediction.
   logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
   logic [31:0] b1_b2_q, mc_md_q;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];

   int  error_count;
   int  sent_count;
   int  checked_count;
   int  div_error_count;
   int  p_high_count;
   int  p_low_count;
   int  stall_request;
   bit  sender_gaps_on;
   bit  receiver_gaps_on;
   int  sender_gap;
   int  receiver_gap;
   int  idle_cycles;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [31:0] sign16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] shift_arith(input logic [31:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   // Truncating signed division built from magnitudes; wraps for -2^31 / -1.
   function automatic logic [31:0] divide_signed(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 9) < 7) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic reading_type compensate_sample(input sample_type s);
      reading_type r;
      logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, t, sq, pr;
      ut  = {16'd0, s.raw_temperature};
      up  = {13'd0, s.raw_pressure};
      ac1 = sign16(ac1_q);
      ac2 = sign16(ac2_q);
      ac3 = sign16(ac3_q);
      ac4 = {16'd0, ac4_q};
      ac5 = {16'd0, ac5_q};
      ac6 = {16'd0, ac6_q};
      b1  = sign16(b1_b2_q[31:16]);
      b2  = sign16(b1_b2_q[15:0]);
      mc  = sign16(mc_md_q[31:16]);
      md  = sign16(mc_md_q[15:0]);
      r   = '0;
      x1 = shift_arith((ut - ac6) * ac5, 15);
      if (x1 + md == 32'd0) begin
         r.divide_error = 1'b1;
         return r;
      end
      x2 = divide_signed(mc << 11, x1 + md);
      b5 = x1 + x2;
      t  = shift_arith(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = shift_arith(b6 * b6, 12);
      x1 = shift_arith(b2 * sq, 11);
      x2 = shift_arith(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shift_arith(((ac1 * 32'd4 + x3) << bpc_pkg::OSS) + 32'd2, 2);
      x1 = shift_arith(ac3 * b6, 13);
      x2 = shift_arith(b1 * sq, 16);
      x3 = shift_arith(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 32'd0) begin
         r.divide_error = 1'b1;
         return r;
      end
      b7 = (up - b3) * (32'd50000 >> bpc_pkg::OSS);
      if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = shift_arith(p, 8) * shift_arith(p, 8);
      x1 = shift_arith(x1 * 32'd3038, 16);
      x2 = shift_arith(32'hFFFF_E343 * p, 16);
      pr = p + shift_arith(x1 + x2 + 32'd3791, 4);
      if (pr[31]) r.pressure_pa = '0;
      else if (pr > 32'd262143) r.pressure_pa = '1;
      else r.pressure_pa = pr[17:0];
      if (t[31]) r.temperature_tenths = (t < 32'hFFFF_8000) ? 16'h8000 : t[15:0];
      else r.temperature_tenths = (t > 32'd32767) ? 16'h7FFF : t[15:0];
      return r;
   endfunction

   // Sender: a new sample is offered only once the previous one has transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid           <= 1'b0;
         req_ch.raw_temperature <= '0;
         req_ch.raw_pressure    <= '0;
         sender_gap             <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (sender_gap > 0) begin
            sender_gap   <= sender_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            sample_type s;
            s = pending_samples.pop_front();
            req_ch.raw_temperature <= s.raw_temperature;
            req_ch.raw_pressure    <= s.raw_pressure;
            req_ch.valid           <= 1'b1;
            sender_gap             <= sender_gaps_on ? random_gap() : 0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         receiver_gap <= 0;
      end else if (stall_request > 0) begin
         rsp_ch.ready  <= 1'b0;
         stall_request <= stall_request - 1;
      end else if (receiver_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         receiver_gap <= receiver_gap - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         receiver_gap <= receiver_gaps_on ? random_gap() : 0;
      end
   end

   // Prediction on input transfers, comparison on result transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sample_type s;
            s.raw_temperature = req_ch.raw_temperature;
            s.raw_pressure    = req_ch.raw_pressure;
            expected_readings.push_back(compensate_sample(s));
            sent_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result transfer with no prediction waiting");
               error_count++;
            end else begin
               reading_type e;
               e = expected_readings.pop_front();
               checked_count++;
               if (e.divide_error) div_error_count++;
               else if (e.pressure_pa == '1) p_high_count++;
               else if (e.pressure_pa == '0) p_low_count++;
               if (rsp_ch.pressure_pa !== e.pressure_pa) begin
                  $error("pressure_pa expected %0d actual %0d", e.pressure_pa,
                         rsp_ch.pressure_pa);
                  error_count++;
               end
               if (rsp_ch.temperature_tenths !== e.temperature_tenths) begin
                  $error("temperature_tenths expected %0d actual %0d",
                         $signed(e.temperature_tenths), $signed(rsp_ch.temperature_tenths));
                  error_count++;
               end
               if (rsp_ch.divide_error !== e.divide_error) begin
                  $error("divide_error expected %0d actual %0d", e.divide_error,
                         rsp_ch.divide_error);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which nothing transfers anywhere.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[barometric_pressure_compensation] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_coef(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bpc_pkg::ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         bpc_pkg::REG_AC1:   ac1_q   = value[15:0];
         bpc_pkg::REG_AC2:   ac2_q   = value[15:0];
         bpc_pkg::REG_AC3:   ac3_q   = value[15:0];
         bpc_pkg::REG_AC4:   ac4_q   = value[15:0];
         bpc_pkg::REG_AC5:   ac5_q   = value[15:0];
         bpc_pkg::REG_AC6:   ac6_q   = value[15:0];
         bpc_pkg::REG_B1_B2: b1_b2_q = value;
         default:            mc_md_q = value;
      endcase
   endtask

   task automatic write_all(input logic [15:0] a1, input logic [15:0] a2,
                            input logic [15:0] a3, input logic [15:0] a4,
                            input logic [15:0] a5, input logic [15:0] a6,
                            input logic [31:0] bb, input logic [31:0] mm);
      write_coef(bpc_pkg::REG_AC1, {16'd0, a1});
      write_coef(bpc_pkg::REG_AC2, {16'd0, a2});
      write_coef(bpc_pkg::REG_AC3, {16'd0, a3});
      write_coef(bpc_pkg::REG_AC4, {16'd0, a4});
      write_coef(bpc_pkg::REG_AC5, {16'd0, a5});
      write_coef(bpc_pkg::REG_AC6, {16'd0, a6});
      write_coef(bpc_pkg::REG_B1_B2, bb);
      write_coef(bpc_pkg::REG_MC_MD, mm);
   endtask

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_ch.valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_sample(input logic [15:0] ut, input logic [18:0] up);
      sample_type s;
      s.raw_temperature = ut;
      s.raw_pressure    = up;
      pending_samples.push_back(s);
   endtask

   // Most random samples sit near a plausible operating point; the rest span the full range.
   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            queue_sample(16'($urandom), 19'($urandom));
         else
            queue_sample(16'($urandom_range(20000, 36000)), 19'($urandom_range(150000, 250000)));
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      stall_request    = 0;
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      error_count      = 0;
      sent_count       = 0;
      checked_count    = 0;
      div_error_count  = 0;
      p_high_count     = 0;
      p_low_count      = 0;
      idle_cycles      = 0;
      ac1_q = 16'd408;   ac2_q = 16'hFFB8;  ac3_q = 16'hC7D1;
      ac4_q = 16'd32741; ac5_q = 16'd32757; ac6_q = 16'd23153;
      b1_b2_q = 32'd405667844;
      mc_md_q = 32'd3724086068;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed samples on reset coefficients: extremes, bit patterns and nominal points.
      queue_sample(16'd0, 19'd0);
      queue_sample(16'hFFFF, 19'h7FFFF);
      queue_sample(16'd0, 19'h7FFFF);
      queue_sample(16'hFFFF, 19'd0);
      queue_sample(16'd27898, 19'd190744);
      queue_sample(16'h5555, 19'h2AAAA);
      queue_sample(16'hAAAA, 19'h55555);
      queue_sample(16'd23153, 19'd200000);
      queue_random(150);
      wait_idle();

      // A zero temperature divisor: no gain and md of zero.
      write_all(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd0, 16'd23153,
                32'd405667844, 32'hDD1C_0000);
      queue_sample(16'd27898, 19'd190744);
      queue_sample(16'hFFFF, 19'd0);
      wait_idle();

      // With no gain, md and mc at their minimum run the temperature division on two
      // negative operands; ac4 of zero forces a zero pressure divisor.
      write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0,
                32'h8000_7FFF, 32'h8000_8000);
      queue_sample(16'd0, 19'd0);
      queue_sample(16'hFFFF, 19'h7FFFF);
      wait_idle();

      // Coefficient extremes, maximum side.
      write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                32'h7FFF_7FFF, 32'h7FFF_7FFF);
      queue_sample(16'd0, 19'd0);
      queue_sample(16'hFFFF, 19'h7FFFF);
      queue_random(60);
      wait_idle();

      // Coefficient extremes, minimum side.
      write_all(16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd1, 16'd0,
                32'h8000_8000, 32'h8000_8001);
      queue_sample(16'd0, 19'h7FFFF);
      queue_sample(16'hFFFF, 19'd0);
      queue_random(60);
      wait_idle();

      // Back to nominal coefficients: a long receiver hold-off while samples keep coming.
      write_all(16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd32757, 16'd23153,
                32'd405667844, 32'd3724086068);
      sender_gaps_on = 1'b0;
      queue_random(200);
      repeat (10) @(posedge clock);
      stall_request = 300;
      // Wait mid-phase until every queued sample has been sent and every prediction met.
      while (pending_samples.size() > 0 || req_ch.valid || expected_readings.size() > 0)
         @(posedge clock);
      receiver_gaps_on = 1'b0;
      queue_random(100);
      wait_idle();
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;

      // Several random coefficient sets.
      for (int k = 0; k < 4; k++) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), $urandom, $urandom);
         queue_random(80);
         wait_idle();
      end

      while (expected_readings.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d samples over ten coefficient sets, %0d results checked.",
               sent_count, checked_count);
      $display("Divide errors %0d, pressure saturated high %0d, low %0d.",
               div_error_count, p_high_count, p_low_count);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("[barometric_pressure_compensation] OK");
      end else begin
         if (expected_readings.size() > 0)
            $error("%0d predictions never met", expected_readings.size());
         $display("[barometric_pressure_compensation] ERROR");
      end
      $finish;
   end

endmodule
